// File: sv/eq3_pkg.sv
`timescale 1ns / 1ps

package eq3_pkg;

  localparam int GAIN_W     = 15;
  localparam int GAIN_FRAC  = 14;
  localparam int ORDER_W    = 6;
  localparam int INDEX_W    = 6;
  localparam int BAND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam logic [BAND_W-1:0] BAND_LOW  = 2'd0;
  localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
  localparam logic [BAND_W-1:0] BAND_HIGH = 2'd2;
  localparam logic [BAND_W-1:0] BAND_NONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MID_ORDER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ORDER    = 3'd4;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 15'd16384;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd31;

  // sequencer to datapath strobes
  typedef struct packed {
    logic              issue;
    logic              first;
    logic              total_clr;
    logic              gain_load;
    logic              gain_step;
    logic              capture;
    logic              ch;
    logic [BAND_W-1:0] band;
  } dp_ctl_t;

endpackage

// File: sv/eq3_mem.sv
`timescale 1ns / 1ps

module eq3_mem #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16,
  localparam int TAP_W      = $clog2(MAX_TAPS)
) (
  input  logic                     clk,
  input  logic                     hist_we,
  input  logic [TAP_W-1:0]         hist_waddr,
  input  logic [2*SAMPLE_BITS-1:0] hist_wdata,
  input  logic [TAP_W-1:0]         hist_raddr,
  output logic [2*SAMPLE_BITS-1:0] hist_rdata,
  input  logic                     coef_we,
  input  logic [TAP_W+1:0]         coef_waddr,
  input  logic [COEF_BITS-1:0]     coef_wdata,
  input  logic [TAP_W+1:0]         coef_raddr,
  output logic [COEF_BITS-1:0]     coef_rdata
);

  localparam int HIST_DEPTH = 1 << TAP_W;
  localparam int COEF_DEPTH = 4 << TAP_W;

  // circular history, right sample in the upper half
  logic [2*SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
  // coefficient words addressed by band and tap
  logic [COEF_BITS-1:0]     coef_mem [COEF_DEPTH];

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rdata <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_rdata <= coef_mem[coef_raddr];
  end

endmodule

// File: sv/eq3_dp.sv
`timescale 1ns / 1ps

module eq3_dp #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  eq3_pkg::dp_ctl_t             ctl,
  input  logic [2*SAMPLE_BITS-1:0]     hist_rdata,
  input  logic [COEF_BITS-1:0]         coef_rdata,
  input  logic [eq3_pkg::GAIN_W-1:0]   low_gain,
  input  logic [eq3_pkg::GAIN_W-1:0]   mid_gain,
  input  logic [eq3_pkg::GAIN_W-1:0]   high_gain,
  output logic [SAMPLE_BITS-1:0]       left_res,
  output logic [SAMPLE_BITS-1:0]       right_res
);

  import eq3_pkg::*;

  localparam int TAP_W  = $clog2(MAX_TAPS);
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + TAP_W;
  localparam int TOT_W  = ACC_W + GAIN_W + 2;
  localparam int SH     = COEF_BITS - 1 + GAIN_FRAC;

  localparam logic [TOT_W-1:0] HALF = {{(TOT_W-1){1'b0}}, 1'b1} << (SH - 1);
  localparam logic signed [TOT_W-1:0] HI_LIM =
    {{(TOT_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [TOT_W-1:0] LO_LIM =
    {{(TOT_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  logic                       v1, v2, f1, f2;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]           prod_ext;
  logic [ACC_W-1:0]           acc;
  logic [TOT_W-1:0]           sh;
  logic [GAIN_W-1:0]          g;
  logic [GAIN_W-1:0]          gain_sel;
  logic [TOT_W-1:0]           total;
  logic signed [TOT_W-1:0]    scaled;
  logic [SAMPLE_BITS-1:0]     sat;

  assign smp      = ctl.ch ? hist_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]
                           : hist_rdata[SAMPLE_BITS-1:0];
  assign prod_ext = {{TAP_W{prod[PROD_W-1]}}, prod};

  always_comb begin
    case (ctl.band)
      BAND_LOW:  gain_sel = low_gain;
      BAND_MID:  gain_sel = mid_gain;
      BAND_HIGH: gain_sel = high_gain;
      default:   gain_sel = '0;
    endcase
  end

  // round half up, then clamp to the sample range
  assign scaled = $signed(total + HALF) >>> SH;

  always_comb begin
    if (scaled > HI_LIM) begin
      sat = HI_LIM[SAMPLE_BITS-1:0];
    end else if (scaled < LO_LIM) begin
      sat = LO_LIM[SAMPLE_BITS-1:0];
    end else begin
      sat = scaled[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      f1 <= 1'b0;
      f2 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      f1 <= ctl.first;
      v2 <= v1;
      f2 <= f1;
    end
  end

  // shared multiply-accumulate
  always_ff @(posedge clk) begin
    prod <= smp * $signed(coef_rdata);
    if (v2) begin
      acc <= f2 ? prod_ext : acc + prod_ext;
    end
  end

  // band gain by shift and add, one gain bit a cycle
  always_ff @(posedge clk) begin
    if (ctl.gain_load) begin
      sh <= {{(TOT_W-ACC_W){acc[ACC_W-1]}}, acc};
      g  <= gain_sel;
    end else if (ctl.gain_step) begin
      sh <= sh << 1;
      g  <= g >> 1;
    end
    if (ctl.total_clr) begin
      total <= '0;
    end else if (ctl.gain_step && g[0]) begin
      total <= total + sh;
    end
    if (ctl.capture) begin
      if (ctl.ch) begin
        right_res <= sat;
      end else begin
        left_res <= sat;
      end
    end
  end

endmodule

// File: sv/eq3_ctrl.sv
`timescale 1ns / 1ps

module eq3_ctrl #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16,
  localparam int TAP_W      = $clog2(MAX_TAPS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [2*SAMPLE_BITS-1:0]      in_pair,
  input  logic [eq3_pkg::BAND_W-1:0]    in_band,
  input  logic [eq3_pkg::INDEX_W-1:0]   in_index,
  input  logic [COEF_BITS-1:0]          in_coef,
  input  logic [eq3_pkg::ORDER_W-1:0]   low_mid_order,
  input  logic [eq3_pkg::ORDER_W-1:0]   high_order,
  input  logic                          out_free,
  output logic                          hist_we,
  output logic [TAP_W-1:0]              hist_waddr,
  output logic [2*SAMPLE_BITS-1:0]      hist_wdata,
  output logic [TAP_W-1:0]              hist_raddr,
  output logic                          coef_we,
  output logic [TAP_W+1:0]              coef_waddr,
  output logic [COEF_BITS-1:0]          coef_wdata,
  output logic [TAP_W+1:0]              coef_raddr,
  output eq3_pkg::dp_ctl_t              ctl,
  output logic                          res_valid
);

  import eq3_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_TAP   = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_GAIN  = 7'b0010000,
    ST_ROUND = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  localparam logic [TAP_W-1:0] TOP_TAP    = TAP_W'(MAX_TAPS - 1);
  localparam logic [3:0]       DRAIN_LAST = 4'd2;
  localparam logic [3:0]       GAIN_LAST  = 4'(GAIN_W - 1);

  state_t            state, state_next;
  logic [TAP_W+1:0]  clr_addr;
  logic [TAP_W-1:0]  wptr, raddr, tap;
  logic [TAP_W-1:0]  lm_order, hi_order, last_tap;
  logic [BAND_W-1:0] band;
  logic              ch;
  logic [3:0]        cnt;
  logic              accept, take_sample, load_ok, clearing;

  assign lm_order = (32'(low_mid_order) > MAX_TAPS - 1) ? TOP_TAP : TAP_W'(low_mid_order);
  assign hi_order = (32'(high_order) > MAX_TAPS - 1) ? TOP_TAP : TAP_W'(high_order);
  assign last_tap = (band == BAND_HIGH) ? hi_order : lm_order;

  assign clearing    = (state == ST_CLEAR);
  assign in_ready    = (state == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign take_sample = accept && (in_cmd == CMD_SAMPLE);
  assign load_ok     = (in_band != BAND_NONE) && (32'(in_index) < MAX_TAPS);

  assign hist_we    = clearing || take_sample;
  assign hist_waddr = clearing ? clr_addr[TAP_W-1:0] : wptr + TAP_W'(1);
  assign hist_wdata = clearing ? '0 : in_pair;
  assign hist_raddr = raddr;

  assign coef_we    = clearing || (accept && (in_cmd == CMD_LOAD) && load_ok);
  assign coef_waddr = clearing ? clr_addr : {in_band, TAP_W'(in_index)};
  assign coef_wdata = clearing ? '0 : in_coef;
  assign coef_raddr = {band, tap};

  assign ctl.issue     = (state == ST_TAP);
  assign ctl.first     = (tap == '0);
  assign ctl.total_clr = (state == ST_TAP) && (tap == '0) && (band == BAND_LOW);
  assign ctl.gain_load = (state == ST_DRAIN) && (cnt == DRAIN_LAST);
  assign ctl.gain_step = (state == ST_GAIN);
  assign ctl.capture   = (state == ST_ROUND);
  assign ctl.ch        = ch;
  assign ctl.band      = band;

  assign res_valid = (state == ST_OUT) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (take_sample) state_next = ST_TAP;
      end
      ST_TAP: begin
        if (tap == last_tap) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cnt == DRAIN_LAST) state_next = ST_GAIN;
      end
      ST_GAIN: begin
        if (cnt == GAIN_LAST) state_next = (band == BAND_HIGH) ? ST_ROUND : ST_TAP;
      end
      ST_ROUND: begin
        state_next = ch ? ST_OUT : ST_TAP;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      wptr     <= '0;
      raddr    <= '0;
      tap      <= '0;
      band     <= BAND_LOW;
      ch       <= 1'b0;
      cnt      <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        ST_IDLE: begin
          if (take_sample) begin
            wptr  <= wptr + TAP_W'(1);
            raddr <= wptr + TAP_W'(1);
            tap   <= '0;
            band  <= BAND_LOW;
            ch    <= 1'b0;
          end
        end
        ST_TAP: begin
          if (tap == last_tap) begin
            cnt <= '0;
          end else begin
            tap   <= tap + TAP_W'(1);
            raddr <= raddr - TAP_W'(1);
          end
        end
        ST_DRAIN: begin
          cnt <= (cnt == DRAIN_LAST) ? '0 : cnt + 4'd1;
        end
        ST_GAIN: begin
          if (cnt == GAIN_LAST) begin
            cnt <= '0;
            if (band != BAND_HIGH) begin
              band  <= band + 2'd1;
              tap   <= '0;
              raddr <= wptr;
            end
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_ROUND: begin
          ch    <= 1'b1;
          band  <= BAND_LOW;
          tap   <= '0;
          raddr <= wptr;
        end
        default: begin
        end
      endcase
    end
  end

  a_no_write_in_taps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAP) |-> (!hist_we && !coef_we))
    else $error("memory write during tap walk");

  a_tap_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAP) |-> (tap <= last_tap))
    else $error("tap index past filter order");

  a_first_tap_newest: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_TAP) && (tap == '0)) |-> (raddr == wptr))
    else $error("first tap does not read newest sample");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_cmd == CMD_LOAD)) |=> (state == ST_IDLE))
    else $error("coefficient beat left idle");

  a_right_then_out: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_ROUND) && ch) |=> (state == ST_OUT))
    else $error("result not offered after right channel");

endmodule

// File: sv/three_band_fir_equalizer_core.sv
// Stereo three-band FIR equalizer. A sample beat (tuser 0) pushes one left and one right
// sample into each channel's history and yields one output beat with both equalized
// samples; a coefficient beat (tuser 1) writes one tap of the low, mid or high filter
// and yields nothing. All taps go through one shared multiply-accumulate unit, and each
// band sum is scaled by its gain with a shift-and-add; the low/mid and high orders are
// clamped to MAX_TAPS - 1. After reset the block clears its history and coefficient
// memories before it takes input; configuration writes are taken at any time.
`timescale 1ns / 1ps

module three_band_fir_equalizer_core #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // left_sample, right_sample, coef_band, coef_index, coef_value
  input  logic [((2*SAMPLE_BITS+COEF_BITS+15)/8)*8-1:0] s_axis_tdata,
  // command
  input  logic                                       s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // left_out, right_out
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         m_axis_tdata,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [eq3_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [eq3_pkg::CFG_DATA_W-1:0]             cfg_data
);

  import eq3_pkg::*;

  localparam int TAP_W     = $clog2(MAX_TAPS);
  localparam int OUT_TD_W  = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int BAND_LSB  = 2*SAMPLE_BITS;
  localparam int INDEX_LSB = BAND_LSB + BAND_W;
  localparam int COEF_LSB  = INDEX_LSB + INDEX_W;

  logic [GAIN_W-1:0]          low_gain, mid_gain, high_gain;
  logic [ORDER_W-1:0]         low_mid_order, high_order;
  logic                       out_free, res_valid;
  logic                       hist_we, coef_we;
  logic [TAP_W-1:0]           hist_waddr, hist_raddr;
  logic [2*SAMPLE_BITS-1:0]   hist_wdata, hist_rdata;
  logic [TAP_W+1:0]           coef_waddr, coef_raddr;
  logic [COEF_BITS-1:0]       coef_wdata, coef_rdata;
  logic [SAMPLE_BITS-1:0]     left_res, right_res;
  dp_ctl_t                    ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_gain      <= GAIN_RESET;
      mid_gain      <= GAIN_RESET;
      high_gain     <= GAIN_RESET;
      low_mid_order <= ORDER_RESET;
      high_order    <= ORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_GAIN:      low_gain      <= cfg_data[GAIN_W-1:0];
        REG_MID_GAIN:      mid_gain      <= cfg_data[GAIN_W-1:0];
        REG_HIGH_GAIN:     high_gain     <= cfg_data[GAIN_W-1:0];
        REG_LOW_MID_ORDER: low_mid_order <= cfg_data[ORDER_W-1:0];
        REG_HIGH_ORDER:    high_order    <= cfg_data[ORDER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // output register
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_axis_tdata <= OUT_TD_W'({right_res, left_res});
    end
  end

  eq3_ctrl #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_cmd        (s_axis_tuser),
    .in_pair       (s_axis_tdata[2*SAMPLE_BITS-1:0]),
    .in_band       (s_axis_tdata[INDEX_LSB-1:BAND_LSB]),
    .in_index      (s_axis_tdata[COEF_LSB-1:INDEX_LSB]),
    .in_coef       (s_axis_tdata[COEF_LSB+COEF_BITS-1:COEF_LSB]),
    .low_mid_order (low_mid_order),
    .high_order    (high_order),
    .out_free      (out_free),
    .hist_we       (hist_we),
    .hist_waddr    (hist_waddr),
    .hist_wdata    (hist_wdata),
    .hist_raddr    (hist_raddr),
    .coef_we       (coef_we),
    .coef_waddr    (coef_waddr),
    .coef_wdata    (coef_wdata),
    .coef_raddr    (coef_raddr),
    .ctl           (ctl),
    .res_valid     (res_valid)
  );

  eq3_mem #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_mem (
    .clk        (clk),
    .hist_we    (hist_we),
    .hist_waddr (hist_waddr),
    .hist_wdata (hist_wdata),
    .hist_raddr (hist_raddr),
    .hist_rdata (hist_rdata),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .coef_raddr (coef_raddr),
    .coef_rdata (coef_rdata)
  );

  eq3_dp #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .hist_rdata (hist_rdata),
    .coef_rdata (coef_rdata),
    .low_gain   (low_gain),
    .mid_gain   (mid_gain),
    .high_gain  (high_gain),
    .left_res   (left_res),
    .right_res  (right_res)
  );

endmodule

// File: sim/three_band_fir_equalizer_core_tb.sv
`timescale 1ns / 1ps

module three_band_fir_equalizer_core_tb;
  import eq3_pkg::*;

  localparam int MAX_TAPS    = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int IN_W        = ((2*SAMPLE_BITS+COEF_BITS+15)/8)*8;
  localparam int OUT_W       = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int SHIFT       = COEF_BITS - 1 + GAIN_FRAC;
  localparam int RANDOM_BEATS = 650;
  localparam int NUM_ROWS    = 26;
  localparam int SETTLE      = 10;
  localparam int DRAIN       = 600;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [GAIN_W-1:0]    GAIN_1P5   = 15'd24576;
  localparam logic [GAIN_W-1:0]    GAIN_MAX   = 15'h7FFF;
  localparam logic [ORDER_W-1:0]   ORDER_MAX  = 6'd63;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  typedef struct {
    sample_t left;
    sample_t right;
  } stereo_t;

  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic                   cmd;
    sample_t                left;
    sample_t                right;
    logic [BAND_W-1:0]      band;
    logic [INDEX_W-1:0]     index;
    coef_t                  coef;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    bit                     fixed;
    stereo_t                want;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // left_sample, right_sample, coef_band, coef_index, coef_value
  logic [IN_W-1:0]       s_axis_tdata;
  // command
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // left_out, right_out
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  three_band_fir_equalizer_core #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // equalizer shadow state
  sample_t             hist_l [MAX_TAPS];
  sample_t             hist_r [MAX_TAPS];
  coef_t               taps_low [MAX_TAPS];
  coef_t               taps_mid [MAX_TAPS];
  coef_t               taps_high [MAX_TAPS];
  logic [GAIN_W-1:0]   gain_low;
  logic [GAIN_W-1:0]   gain_mid;
  logic [GAIN_W-1:0]   gain_high;
  logic [ORDER_W-1:0]  order_lm;
  logic [ORDER_W-1:0]  order_hi;

  stereo_t pending_out [$];
  bit      fixed_next;
  stereo_t fixed_val;
  bit      calm;
  int      errors;

  row_t plan [NUM_ROWS];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #15_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic sample_t equalize_channel(bit right);
    longint  acc_low;
    longint  acc_mid;
    longint  acc_high;
    longint  total;
    longint  x;
    acc_low  = 0;
    acc_mid  = 0;
    acc_high = 0;
    for (int i = 0; i < MAX_TAPS; i++) begin
      x = right ? longint'(hist_r[i]) : longint'(hist_l[i]);
      if (i <= order_lm) begin
        acc_low += x * longint'(taps_low[i]);
        acc_mid += x * longint'(taps_mid[i]);
      end
      if (i <= order_hi) begin
        acc_high += x * longint'(taps_high[i]);
      end
    end
    total = acc_low * longint'(gain_low) + acc_mid * longint'(gain_mid)
          + acc_high * longint'(gain_high);
    total = (total + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
    if (total > 32767) total = 32767;
    if (total < -32768) total = -32768;
    return sample_t'(total);
  endfunction

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic row_t load_row(logic [BAND_W-1:0] band, logic [INDEX_W-1:0] idx,
                                    coef_t c);
    row_t r;
    r = '{kind: ROW_BEAT, default: '0};
    r.kind  = ROW_BEAT;
    r.cmd   = CMD_LOAD;
    r.band  = band;
    r.index = idx;
    r.coef  = c;
    return r;
  endfunction

  function automatic row_t sample_row(sample_t l, sample_t rt);
    row_t r;
    r = '{kind: ROW_BEAT, default: '0};
    r.kind  = ROW_BEAT;
    r.cmd   = CMD_SAMPLE;
    r.left  = l;
    r.right = rt;
    return r;
  endfunction

  function automatic row_t sample_chk(sample_t l, sample_t rt, sample_t wl, sample_t wr);
    row_t r;
    r = sample_row(l, rt);
    r.fixed      = 1'b1;
    r.want.left  = wl;
    r.want.right = wr;
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_beat(sample_t l, sample_t r,
                                                 logic [BAND_W-1:0] band,
                                                 logic [INDEX_W-1:0] idx, coef_t c);
    return {c, idx, band, r, l};
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 2047) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return GAIN_1P5;
      2: return GAIN_MAX;
      default: return CFG_DATA_W'($urandom_range(0, 24576));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_order();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_DATA_W'(ORDER_MAX);
      2: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, 40));
    endcase
  endfunction

  // scoreboard and shadow update
  always @(posedge clk) begin
    stereo_t got;
    stereo_t want;
    sample_t l_in;
    sample_t r_in;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOW_GAIN:      gain_low  = cfg_data[GAIN_W-1:0];
          REG_MID_GAIN:      gain_mid  = cfg_data[GAIN_W-1:0];
          REG_HIGH_GAIN:     gain_high = cfg_data[GAIN_W-1:0];
          REG_LOW_MID_ORDER: order_lm  = cfg_data[ORDER_W-1:0];
          REG_HIGH_ORDER:    order_hi  = cfg_data[ORDER_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.left  = m_axis_tdata[SAMPLE_BITS-1:0];
        got.right = m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        if (pending_out.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected output beat: left %0d right %0d", got.left, got.right);
        end else begin
          want = pending_out.pop_front();
          if (got.left !== want.left || got.right !== want.right) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: left_out exp %0d got %0d, right_out exp %0d got %0d",
                       want.left, got.left, want.right, got.right);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        l_in = s_axis_tdata[SAMPLE_BITS-1:0];
        r_in = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        if (s_axis_tuser == CMD_LOAD) begin
          case (s_axis_tdata[2*SAMPLE_BITS +: BAND_W])
            BAND_LOW:  taps_low[s_axis_tdata[2*SAMPLE_BITS+BAND_W +: INDEX_W]] =
                         s_axis_tdata[2*SAMPLE_BITS+BAND_W+INDEX_W +: COEF_BITS];
            BAND_MID:  taps_mid[s_axis_tdata[2*SAMPLE_BITS+BAND_W +: INDEX_W]] =
                         s_axis_tdata[2*SAMPLE_BITS+BAND_W+INDEX_W +: COEF_BITS];
            BAND_HIGH: taps_high[s_axis_tdata[2*SAMPLE_BITS+BAND_W +: INDEX_W]] =
                         s_axis_tdata[2*SAMPLE_BITS+BAND_W+INDEX_W +: COEF_BITS];
            default: ;
          endcase
        end else begin
          for (int i = MAX_TAPS - 1; i > 0; i--) begin
            hist_l[i] = hist_l[i-1];
            hist_r[i] = hist_r[i-1];
          end
          hist_l[0] = l_in;
          hist_r[0] = r_in;
          want.left  = equalize_channel(1'b0);
          want.right = equalize_channel(1'b1);
          pending_out.push_back(fixed_next ? fixed_val : want);
        end
      end
    end
  end

  // output side
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        do @(posedge clk); while (!m_axis_tvalid);
        @(negedge clk);
        repeat (stall - 1) @(negedge clk);
        m_axis_tready <= 1'b1;
      end
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_beat(logic cmd, logic [IN_W-1:0] data);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // hold the input until every pending output beat is back, then let loads settle
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int                    sent;
    int                    phase_len;
    logic                  cmd;
    logic [BAND_W-1:0]     band;
    logic [INDEX_W-1:0]    idx;
    coef_t                 c;
    sample_t               l;
    sample_t               r;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_SAMPLE;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    fixed_next    = 1'b0;
    fixed_val     = '{default: '0};
    calm          = 1'b0;
    errors        = 0;
    gain_low      = GAIN_RESET;
    gain_mid      = GAIN_RESET;
    gain_high     = GAIN_RESET;
    order_lm      = ORDER_RESET;
    order_hi      = ORDER_RESET;
    for (int i = 0; i < MAX_TAPS; i++) begin
      hist_l[i]    = '0;
      hist_r[i]    = '0;
      taps_low[i]  = '0;
      taps_mid[i]  = '0;
      taps_high[i] = '0;
    end

    plan = '{
      // all taps cleared by reset
      sample_chk(16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0),
      sample_chk(16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0),
      // one low tap at full negative scale, unity gain
      load_row(BAND_LOW, 6'd0, 16'sh8000),
      sample_chk(16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sd32767),
      // gain 1.5 drives both channels into saturation
      cfg_row(REG_LOW_GAIN, GAIN_1P5),
      sample_chk(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF),
      cfg_row(REG_LOW_GAIN, '0),
      sample_chk(16'sh8000, 16'sh8000, 16'sd0, 16'sd0),
      load_row(BAND_MID, 6'd63, 16'sh7FFF),
      load_row(BAND_HIGH, 6'd0, 16'sd12345),
      // unused band is dropped
      load_row(BAND_NONE, 6'd0, 16'sd777),
      load_row(BAND_HIGH, 6'd63, 16'sh8000),
      cfg_row(REG_MID_GAIN, GAIN_MAX),
      cfg_row(REG_HIGH_GAIN, GAIN_1P5),
      cfg_row(REG_LOW_MID_ORDER, CFG_DATA_W'(ORDER_MAX)),
      cfg_row(REG_HIGH_ORDER, '0),
      sample_row(16'sd1000, -16'sd1000),
      sample_row(16'sh7FFF, 16'sh8000),
      load_row(BAND_LOW, 6'd31, 16'sd16384),
      cfg_row(REG_UNUSED, 15'h7FFF),
      cfg_row(REG_LOW_GAIN, GAIN_RESET),
      cfg_row(REG_HIGH_ORDER, 15'h7FFF),
      cfg_row(REG_LOW_MID_ORDER, '0),
      sample_row(-16'sd1, 16'sd1),
      sample_row(16'sd0, 16'sd0),
      sample_row(16'sd12345, -16'sd23456)
    };

    rst = 1'b1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int k = 0; k < NUM_ROWS; k++) begin
      if (plan[k].kind == ROW_CFG) begin
        drain_outputs();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        fixed_next = plan[k].fixed;
        fixed_val  = plan[k].want;
        send_beat(plan[k].cmd, pack_beat(plan[k].left, plan[k].right, plan[k].band,
                                         plan[k].index, plan[k].coef));
        fixed_next = 1'b0;
      end
    end

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      drain_outputs();
      if ($urandom_range(0, 1)) write_reg(REG_LOW_GAIN, pick_gain());
      if ($urandom_range(0, 1)) write_reg(REG_MID_GAIN, pick_gain());
      if ($urandom_range(0, 1)) write_reg(REG_HIGH_GAIN, pick_gain());
      if ($urandom_range(0, 1)) write_reg(REG_LOW_MID_ORDER, pick_order());
      if ($urandom_range(0, 1)) write_reg(REG_HIGH_ORDER, pick_order());
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_HIGH_ORDER + 1, REG_UNUSED)),
                  CFG_DATA_W'($urandom));
      calm      = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 80);
      for (int n = 0; n < phase_len; n++) begin
        cmd  = ($urandom_range(0, 9) < 3) ? CMD_LOAD : CMD_SAMPLE;
        band = ($urandom_range(0, 15) == 0) ? BAND_NONE : BAND_W'($urandom_range(0, 2));
        idx  = $urandom_range(0, 1) ? INDEX_W'($urandom_range(0, 7))
                                    : INDEX_W'($urandom_range(0, 63));
        c    = ($urandom_range(0, 3) == 0) ? coef_t'(0) : coef_t'(rand_word());
        l    = rand_word();
        r    = rand_word();
        send_beat(cmd, pack_beat(l, r, band, idx, c));
        if (!(cmd == CMD_LOAD && band == BAND_NONE)) sent++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    errors += pending_out.size();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/eq3_pkg.sv
sv/eq3_mem.sv
sv/eq3_dp.sv
sv/eq3_ctrl.sv
sv/three_band_fir_equalizer_core.sv
sim/three_band_fir_equalizer_core_tb.sv
